// ===== rtl/three_band_gain_with_feedback_tail_top_defines.svh =====
// Assertion macros shared by the RTL of the three-band gain block
`ifndef THREE_BAND_GAIN_WITH_FEEDBACK_TAIL_TOP_DEFINES_SVH
`define THREE_BAND_GAIN_WITH_FEEDBACK_TAIL_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TBG_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tbg: implication check failed");
`define TBG_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tbg: next-cycle check failed");
`else
`define TBG_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define TBG_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/tbg_pkg.sv =====
// Types, constants, microcode table and helpers for the three-band gain block
package tbg_pkg;

    localparam int STEP_W     = 5;
    localparam int SAMPLE_W   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int GAIN_W     = 15;
    localparam int FB_W       = 16;
    localparam int TW_W       = 15;
    localparam int MIX_W      = 17;
    localparam int OG_W       = 15;
    localparam int FRAC_W     = 16;
    localparam int FILT_W     = 40;
    localparam int TAIL_W     = 48;
    localparam int WET_W      = 47;
    localparam int X_W        = 48;
    localparam int ACC_W      = 50;
    localparam int OPA_W      = 49;
    localparam int OPB_W      = 17;
    localparam int MLO_W      = 24;
    localparam int MHI_W      = OPA_W - MLO_W;
    localparam int MP_W       = MHI_W + OPB_W + 1;
    localparam int PROD_W     = 68;
    localparam int SUM_W      = 70;

    localparam logic [STEP_W-1:0] STEP_START = '0;

    localparam logic [OPB_W-1:0]  LOW_COEFF  = 17'd1860;
    localparam logic [OPB_W-1:0]  HIGH_COEFF = 17'd17669;
    localparam logic [GAIN_W-1:0] GAIN_MIN   = 15'd8192;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 15'd29491;
    localparam logic [FB_W-1:0]   FB_MAX     = 16'd60948;
    localparam logic [MIX_W-1:0]  MIX_MAX    = 17'd65536;

    localparam logic [GAIN_W-1:0] LOW_GAIN_RST    = 15'd16384;
    localparam logic [GAIN_W-1:0] MID_GAIN_RST    = 15'd16384;
    localparam logic [GAIN_W-1:0] HIGH_GAIN_RST   = 15'd16384;
    localparam logic [FB_W-1:0]   FEEDBACK_RST    = 16'd42598;
    localparam logic [TW_W-1:0]   TAIL_WEIGHT_RST = 15'd10322;
    localparam logic [MIX_W-1:0]  MIX_RST         = 17'd65536;
    localparam logic [OG_W-1:0]   OUT_GAIN_RST    = 15'd4096;

    localparam logic signed [PROD_W-1:0] RND14 = PROD_W'(1) << 13;
    localparam logic signed [PROD_W-1:0] RND16 = PROD_W'(1) << 15;
    localparam logic signed [PROD_W-1:0] RND28 = PROD_W'(1) << 27;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_GAIN,
        CFG_MID_GAIN,
        CFG_HIGH_GAIN,
        CFG_FEEDBACK,
        CFG_TAIL_WEIGHT,
        CFG_MIX,
        CFG_OUT_GAIN
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_WAIT_OUT
    } seq_op_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_LO,
        MUL_HI
    } mul_op_t;

    typedef enum logic [2:0] {
        A_DRY_MINUS_A,
        A_DRY_MINUS_B,
        A_FILT_A,
        A_B_MINUS_A,
        A_TAIL,
        A_X_MINUS_DRY,
        A_X
    } asel_t;

    typedef enum logic [3:0] {
        B_LOW_COEFF,
        B_HIGH_COEFF,
        B_LOW_GAIN,
        B_MID_GAIN,
        B_HIGH_GAIN,
        B_FEEDBACK,
        B_TAIL_WEIGHT,
        B_MIX,
        B_OUT_GAIN
    } bsel_t;

    typedef enum logic [3:0] {
        P_NONE,
        P_FILT_A,
        P_FILT_B,
        P_ACC_SET,
        P_ACC_ADD,
        P_TAIL,
        P_WET,
        P_MIX,
        P_OUT
    } post_op_t;

    typedef struct packed {
        seq_op_t             seq;
        mul_op_t             mul;
        asel_t               asel;
        bsel_t               bsel;
        post_op_t            post;
        logic [STEP_W-1:0]   target;
    } cw_t;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
    } seq_stat_t;

    typedef struct packed {
        cw_t               cw;
        logic              go;
        logic [STEP_W-1:0] step;
    } seq_ctl_t;

    function automatic cw_t mk_cw(input seq_op_t seq, input mul_op_t mul, input asel_t asel,
                                  input bsel_t bsel, input post_op_t post);
        cw_t w;
        w.seq    = seq;
        w.mul    = mul;
        w.asel   = asel;
        w.bsel   = bsel;
        w.post   = post;
        w.target = STEP_START;
        return w;
    endfunction

    function automatic cw_t ucode(input logic [STEP_W-1:0] step);
        cw_t w;
        case (step)
            5'd0:  w = mk_cw(SEQ_WAIT_IN,  MUL_NONE, A_DRY_MINUS_A, B_LOW_COEFF,   P_NONE);
            5'd1:  w = mk_cw(SEQ_NEXT,     MUL_LO,   A_DRY_MINUS_A, B_LOW_COEFF,   P_NONE);
            5'd2:  w = mk_cw(SEQ_NEXT,     MUL_HI,   A_DRY_MINUS_A, B_LOW_COEFF,   P_NONE);
            5'd3:  w = mk_cw(SEQ_NEXT,     MUL_LO,   A_DRY_MINUS_B, B_HIGH_COEFF,  P_FILT_A);
            5'd4:  w = mk_cw(SEQ_NEXT,     MUL_HI,   A_DRY_MINUS_B, B_HIGH_COEFF,  P_NONE);
            5'd5:  w = mk_cw(SEQ_NEXT,     MUL_LO,   A_FILT_A,      B_LOW_GAIN,    P_FILT_B);
            5'd6:  w = mk_cw(SEQ_NEXT,     MUL_HI,   A_FILT_A,      B_LOW_GAIN,    P_NONE);
            5'd7:  w = mk_cw(SEQ_NEXT,     MUL_LO,   A_B_MINUS_A,   B_MID_GAIN,    P_ACC_SET);
            5'd8:  w = mk_cw(SEQ_NEXT,     MUL_HI,   A_B_MINUS_A,   B_MID_GAIN,    P_NONE);
            5'd9:  w = mk_cw(SEQ_NEXT,     MUL_LO,   A_DRY_MINUS_B, B_HIGH_GAIN,   P_ACC_ADD);
            5'd10: w = mk_cw(SEQ_NEXT,     MUL_HI,   A_DRY_MINUS_B, B_HIGH_GAIN,   P_NONE);
            5'd11: w = mk_cw(SEQ_NEXT,     MUL_LO,   A_TAIL,        B_FEEDBACK,    P_ACC_ADD);
            5'd12: w = mk_cw(SEQ_NEXT,     MUL_HI,   A_TAIL,        B_FEEDBACK,    P_NONE);
            5'd13: w = mk_cw(SEQ_NEXT,     MUL_NONE, A_TAIL,        B_FEEDBACK,    P_TAIL);
            5'd14: w = mk_cw(SEQ_NEXT,     MUL_LO,   A_TAIL,        B_TAIL_WEIGHT, P_NONE);
            5'd15: w = mk_cw(SEQ_NEXT,     MUL_HI,   A_TAIL,        B_TAIL_WEIGHT, P_NONE);
            5'd16: w = mk_cw(SEQ_NEXT,     MUL_NONE, A_TAIL,        B_TAIL_WEIGHT, P_WET);
            5'd17: w = mk_cw(SEQ_NEXT,     MUL_LO,   A_X_MINUS_DRY, B_MIX,         P_NONE);
            5'd18: w = mk_cw(SEQ_NEXT,     MUL_HI,   A_X_MINUS_DRY, B_MIX,         P_NONE);
            5'd19: w = mk_cw(SEQ_NEXT,     MUL_NONE, A_X_MINUS_DRY, B_MIX,         P_MIX);
            5'd20: w = mk_cw(SEQ_NEXT,     MUL_LO,   A_X,           B_OUT_GAIN,    P_NONE);
            5'd21: w = mk_cw(SEQ_NEXT,     MUL_HI,   A_X,           B_OUT_GAIN,    P_NONE);
            5'd22: w = mk_cw(SEQ_WAIT_OUT, MUL_NONE, A_X,           B_OUT_GAIN,    P_OUT);
            default: w = mk_cw(SEQ_WAIT_OUT, MUL_NONE, A_X, B_OUT_GAIN, P_NONE);
        endcase
        return w;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v,
                                                        input int unsigned bits);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = $signed((SUM_W'(1) << (bits - 1)) - SUM_W'(1));
        lo = ~hi;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] v);
        if (v < GAIN_MIN) begin
            return GAIN_MIN;
        end
        if (v > GAIN_MAX) begin
            return GAIN_MAX;
        end
        return v;
    endfunction

endpackage

// ===== rtl/tbg_seq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps
module tbg_seq
    import tbg_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  seq_stat_t stat,
    output seq_ctl_t  ctl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    cw_t               cw;
    logic              go;

    assign cw = ucode(step_reg);

    always_comb begin
        step_next = step_reg;
        go        = 1'b0;
        case (cw.seq)
            SEQ_NEXT: begin
                go        = 1'b1;
                step_next = step_reg + STEP_W'(1);
            end
            SEQ_WAIT_IN: begin
                go = stat.in_valid;
                if (stat.in_valid) begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            SEQ_WAIT_OUT: begin
                go = !stat.out_busy;
                if (!stat.out_busy) begin
                    step_next = cw.target;
                end
            end
            default: begin
                step_next = STEP_START;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_START;
        end else begin
            step_reg <= step_next;
        end
    end

    assign ctl.cw   = cw;
    assign ctl.go   = go;
    assign ctl.step = step_reg;

endmodule

// ===== rtl/three_band_gain_with_feedback_tail_top.sv =====
// Three-band gain with feedback tail: top level with datapath and output register
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+--------------------------------------------
//  input    | in  | s_tvalid/s_tready  | s_tdata: sample; s_tuser: channel, block_start
//  result   | out | m_tvalid/m_tready  | m_tdata: processed; m_tuser: out_channel
//  config   | in  | cfg_we             | cfg_index, cfg_wdata
//
//  A word is accepted at the first microcode step and its result is registered at the
//  last; the next word is not taken before then. The pace is set by the single 25x18
//  multiplier, which makes nine products in two passes each under microcode.
//  Reset is synchronous, active low, and clears the filter and tail state.
//  A waiting result holds the sequencer in its last step; input is taken meanwhile
//  only once that result has been loaded into the output register.
`include "three_band_gain_with_feedback_tail_top_defines.svh"
module three_band_gain_with_feedback_tail_top
    import tbg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [23:0] sample
    input  logic [1:0]            s_tuser,   // [0] channel, [1] block_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,   // [23:0] processed
    output logic                  m_tuser,   // [0] out_channel
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [GAIN_W-1:0] low_gain_reg;
    logic [GAIN_W-1:0] mid_gain_reg;
    logic [GAIN_W-1:0] high_gain_reg;
    logic [FB_W-1:0]   feedback_reg;
    logic [TW_W-1:0]   tail_weight_reg;
    logic [MIX_W-1:0]  mix_reg;
    logic [OG_W-1:0]   out_gain_reg;

    logic signed [FILT_W-1:0] low_filter_reg  [2];
    logic signed [FILT_W-1:0] high_filter_reg [2];
    logic signed [TAIL_W-1:0] tail_accum_reg  [2];

    logic signed [FILT_W-1:0] dry_reg, dry_next;
    logic signed [FILT_W-1:0] a_reg, a_next;
    logic signed [FILT_W-1:0] b_reg, b_next;
    logic signed [TAIL_W-1:0] t_reg, t_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [X_W-1:0]    x_reg, x_next;
    logic                     ch_reg, ch_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [MHI_W-1:0]  ahi_reg, ahi_next;
    logic [OPB_W-1:0]         bop_reg, bop_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0]      m_tdata_reg, m_tdata_next;
    logic                     m_tuser_reg, m_tuser_next;

    seq_stat_t seq_stat;
    seq_ctl_t  seq_ctl;
    cw_t       cw;

    logic                     in_acc;
    logic                     out_load;
    logic                     tail_wr;
    logic signed [OPA_W-1:0]  opa;
    logic [OPB_W-1:0]         opb;
    logic signed [MHI_W-1:0]  mul_x;
    logic signed [OPB_W:0]    mul_y;
    logic signed [MP_W-1:0]   mul_p;
    logic signed [PROD_W-1:0] r14, r16, r28;
    logic signed [SUM_W-1:0]  post_sum;

    assign seq_stat.in_valid = s_tvalid;
    assign seq_stat.out_busy = m_tvalid_reg && !m_tready;

    tbg_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (seq_stat),
        .ctl     (seq_ctl)
    );

    assign cw       = seq_ctl.cw;
    assign s_tready = (cw.seq == SEQ_WAIT_IN);
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = seq_ctl.go && (cw.post == P_OUT);
    assign tail_wr  = seq_ctl.go && (cw.post == P_TAIL);

    always_comb begin
        case (cw.asel)
            A_DRY_MINUS_A: opa = OPA_W'(dry_reg) - OPA_W'(a_reg);
            A_DRY_MINUS_B: opa = OPA_W'(dry_reg) - OPA_W'(b_reg);
            A_FILT_A:      opa = OPA_W'(a_reg);
            A_B_MINUS_A:   opa = OPA_W'(b_reg) - OPA_W'(a_reg);
            A_TAIL:        opa = OPA_W'(t_reg);
            A_X_MINUS_DRY: opa = OPA_W'(x_reg) - OPA_W'(dry_reg);
            A_X:           opa = OPA_W'(x_reg);
            default:       opa = '0;
        endcase
        case (cw.bsel)
            B_LOW_COEFF:   opb = LOW_COEFF;
            B_HIGH_COEFF:  opb = HIGH_COEFF;
            B_LOW_GAIN:    opb = OPB_W'(low_gain_reg);
            B_MID_GAIN:    opb = OPB_W'(mid_gain_reg);
            B_HIGH_GAIN:   opb = OPB_W'(high_gain_reg);
            B_FEEDBACK:    opb = OPB_W'(feedback_reg);
            B_TAIL_WEIGHT: opb = OPB_W'(tail_weight_reg);
            B_MIX:         opb = mix_reg;
            B_OUT_GAIN:    opb = OPB_W'(out_gain_reg);
            default:       opb = '0;
        endcase
    end

    // low half unsigned on the first pass, signed high half on the second
    assign mul_x = (cw.mul == MUL_LO) ? $signed({1'b0, opa[MLO_W-1:0]}) : ahi_reg;
    assign mul_y = $signed({1'b0, ((cw.mul == MUL_LO) ? opb : bop_reg)});
    assign mul_p = mul_x * mul_y;

    assign r14 = (prod_reg + RND14) >>> 14;
    assign r16 = (prod_reg + RND16) >>> 16;
    assign r28 = (prod_reg + RND28) >>> 28;

    always_comb begin
        case (cw.post)
            P_FILT_A:  post_sum = sat_sum(SUM_W'(a_reg) + SUM_W'(r16), FILT_W);
            P_FILT_B:  post_sum = sat_sum(SUM_W'(b_reg) + SUM_W'(r16), FILT_W);
            P_ACC_SET: post_sum = SUM_W'(r14);
            P_ACC_ADD: post_sum = SUM_W'(acc_reg) + SUM_W'(r14);
            P_TAIL:    post_sum = sat_sum(SUM_W'(acc_reg) + SUM_W'(r16), TAIL_W);
            P_WET:     post_sum = sat_sum(SUM_W'(acc_reg) + SUM_W'(r16), WET_W);
            P_MIX:     post_sum = SUM_W'(dry_reg) + SUM_W'(r16);
            P_OUT:     post_sum = sat_sum(SUM_W'(r28), SAMPLE_W);
            default:   post_sum = '0;
        endcase
    end

    always_comb begin
        dry_next      = dry_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        t_next        = t_reg;
        acc_next      = acc_reg;
        x_next        = x_reg;
        ch_next       = ch_reg;
        prod_next     = prod_reg;
        ahi_next      = ahi_reg;
        bop_next      = bop_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        if (in_acc) begin
            dry_next = $signed({s_tdata, {FRAC_W{1'b0}}});
            ch_next  = s_tuser[0];
            a_next   = s_tuser[1] ? '0 : low_filter_reg[s_tuser[0]];
            b_next   = s_tuser[1] ? '0 : high_filter_reg[s_tuser[0]];
            t_next   = tail_accum_reg[s_tuser[0]];
        end

        if (seq_ctl.go) begin
            case (cw.mul)
                MUL_LO: begin
                    prod_next = PROD_W'(mul_p);
                    ahi_next  = opa[OPA_W-1:MLO_W];
                    bop_next  = opb;
                end
                MUL_HI: begin
                    prod_next = prod_reg + (PROD_W'(mul_p) <<< MLO_W);
                end
                default: begin
                    prod_next = prod_reg;
                end
            endcase
            case (cw.post)
                P_FILT_A:  a_next   = FILT_W'(post_sum);
                P_FILT_B:  b_next   = FILT_W'(post_sum);
                P_ACC_SET: acc_next = ACC_W'(post_sum);
                P_ACC_ADD: acc_next = ACC_W'(post_sum);
                P_TAIL:    t_next   = TAIL_W'(post_sum);
                P_WET:     x_next   = X_W'(post_sum);
                P_MIX:     x_next   = X_W'(post_sum);
                P_OUT: begin
                    m_tdata_next  = post_sum[SAMPLE_W-1:0];
                    m_tuser_next  = ch_reg;
                    m_tvalid_next = 1'b1;
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        dry_reg     <= dry_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        t_reg       <= t_next;
        acc_reg     <= acc_next;
        x_reg       <= x_next;
        ch_reg      <= ch_next;
        prod_reg    <= prod_next;
        ahi_reg     <= ahi_next;
        bop_reg     <= bop_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // write back filters and tail once the tail is settled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                low_filter_reg[i]  <= '0;
                high_filter_reg[i] <= '0;
                tail_accum_reg[i]  <= '0;
            end
        end else if (tail_wr) begin
            low_filter_reg[ch_reg]  <= a_reg;
            high_filter_reg[ch_reg] <= b_reg;
            tail_accum_reg[ch_reg]  <= t_next;
        end
    end

    // clamp gains, feedback and mix on write; tail weight and output gain are stored as written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_gain_reg    <= LOW_GAIN_RST;
            mid_gain_reg    <= MID_GAIN_RST;
            high_gain_reg   <= HIGH_GAIN_RST;
            feedback_reg    <= FEEDBACK_RST;
            tail_weight_reg <= TAIL_WEIGHT_RST;
            mix_reg         <= MIX_RST;
            out_gain_reg    <= OUT_GAIN_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_LOW_GAIN:    low_gain_reg  <= clamp_gain(cfg_wdata[GAIN_W-1:0]);
                CFG_MID_GAIN:    mid_gain_reg  <= clamp_gain(cfg_wdata[GAIN_W-1:0]);
                CFG_HIGH_GAIN:   high_gain_reg <= clamp_gain(cfg_wdata[GAIN_W-1:0]);
                CFG_FEEDBACK: begin
                    feedback_reg <= (cfg_wdata[FB_W-1:0] > FB_MAX) ? FB_MAX
                                                                   : cfg_wdata[FB_W-1:0];
                end
                CFG_TAIL_WEIGHT: tail_weight_reg <= cfg_wdata[TW_W-1:0];
                CFG_MIX: begin
                    mix_reg <= (cfg_wdata[MIX_W-1:0] > MIX_MAX) ? MIX_MAX
                                                                : cfg_wdata[MIX_W-1:0];
                end
                CFG_OUT_GAIN:    out_gain_reg <= cfg_wdata[OG_W-1:0];
                default: begin
                    out_gain_reg <= out_gain_reg;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `TBG_ASSERT_IMPL(a_accept_at_start, aclk, aresetn, in_acc, seq_ctl.step == STEP_START)
    `TBG_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, out_load, !m_tvalid_reg || m_tready)
    `TBG_ASSERT_NEXT(a_load_sets_valid, aclk, aresetn, out_load, m_tvalid_reg)
    `TBG_ASSERT_NEXT(a_channel_held, aclk, aresetn, seq_ctl.step != STEP_START, $stable(ch_reg))

endmodule
